// File: design/lgfs_pkg.sv
// Shared types and constants for the labeled graph frontier stepper.
package lgfs_pkg;

	localparam int ROW_W  = 64;
	localparam int FUNC_W = 2;
	localparam int MODE_W = 3;
	localparam int CITY_W = 6;

	localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd3;

	typedef struct packed {
		logic             en;
		logic             we;
		logic [ROW_W-1:0] wdata;
	} mem_cmd_t;

endpackage

// File: design/lgfs_route_mem.sv
// Single-port synchronous adjacency row memory with registered read data.
module lgfs_route_mem #(
	parameter int DEPTH  = 320,
	parameter int ADDR_W = 9
) (
	input  logic                        clk,
	input  lgfs_pkg::mem_cmd_t          cmd,
	input  logic [ADDR_W-1:0]           addr,
	output logic [lgfs_pkg::ROW_W-1:0]  rdata
);

	logic [lgfs_pkg::ROW_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (cmd.we) begin
				mem[addr] <= cmd.wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: design/labeled_graph_frontier_step.sv
// Top level of the labeled graph frontier stepper: sequencer, state and output register.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  func, mode, city_a, city_b
// out      output     out_valid / out_stall reachable_mask, impossible
//
// Begin and stop transactions complete in the idle state; add edge reads the row, then writes it back.
// A step transaction reads one adjacency row per cycle, for every city, then finishes in ST_STEP_END.
// After reset all NUM_MODES * NUM_CITIES rows of the row memory are cleared with in_stall high.
// A stop transaction is held off while the sequencer is busy or an earlier result is stalled at the output.
module labeled_graph_frontier_step #(
	parameter int NUM_CITIES = 64,
	parameter int NUM_MODES  = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lgfs_pkg::FUNC_W-1:0]   func,
	input  logic [lgfs_pkg::MODE_W-1:0]   mode,
	input  logic [lgfs_pkg::CITY_W-1:0]   city_a,
	input  logic [lgfs_pkg::CITY_W-1:0]   city_b,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lgfs_pkg::ROW_W-1:0]    reachable_mask,
	output logic                          impossible
);

	localparam int DEPTH  = NUM_MODES * NUM_CITIES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LAB_W  = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
	localparam int CNT_W  = $clog2(NUM_CITIES);
	localparam logic [ADDR_W-1:0] NC_A = ADDR_W'(NUM_CITIES);
	localparam logic [lgfs_pkg::ROW_W-1:0] CITY_MASK =
		{lgfs_pkg::ROW_W{1'b1}} >> (lgfs_pkg::ROW_W - NUM_CITIES);

	localparam logic [2:0] ST_CLEAR    = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_ADD      = 3'd2;
	localparam logic [2:0] ST_STEP     = 3'd3;
	localparam logic [2:0] ST_STEP_END = 3'd4;

	logic [2:0]                       state_q;
	logic [ADDR_W-1:0]                clr_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [LAB_W-1:0]                 lab_q;
	logic [ADDR_W-1:0]                add_addr_q;
	logic [lgfs_pkg::CITY_W-1:0]      b_q;
	logic [lgfs_pkg::ROW_W-1:0]       known_q;
	logic [lgfs_pkg::ROW_W-1:0]       frontier_q;
	logic [lgfs_pkg::ROW_W-1:0]       acc_q;
	logic                             vld_s1;
	logic                             sel_s1;
	logic                             out_valid_q;
	logic [lgfs_pkg::ROW_W-1:0]       out_mask_q;
	logic                             out_imp_q;

	logic                             in_acc;
	logic                             stop_acc;
	logic [LAB_W-1:0]                 lab;
	logic                             a_ok;
	logic                             b_ok;
	logic [ADDR_W-1:0]                in_addr;
	logic [lgfs_pkg::ROW_W-1:0]       acc_next;
	lgfs_pkg::mem_cmd_t               cmd;
	logic [ADDR_W-1:0]                mem_addr;
	logic [lgfs_pkg::ROW_W-1:0]       rdata;

	assign in_stall = (state_q != ST_IDLE) ||
		((func == lgfs_pkg::FUNC_STOP) && out_valid_q && out_stall);
	assign in_acc = in_valid && !in_stall;
	assign stop_acc = in_acc && (func == lgfs_pkg::FUNC_STOP);

	assign lab = ({1'b0, mode} >= 4'(NUM_MODES)) ? '0 : LAB_W'(mode);
	assign a_ok = {1'b0, city_a} < 7'(NUM_CITIES);
	assign b_ok = {1'b0, city_b} < 7'(NUM_CITIES);
	assign in_addr = ADDR_W'(lab) * NC_A + ADDR_W'(city_a);
	assign acc_next = acc_q | ((vld_s1 && sel_s1) ? rdata : '0);

	always_comb begin
		cmd = '0;
		mem_addr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.en = 1'b1;
				cmd.we = 1'b1;
				mem_addr = clr_q;
			end
			ST_IDLE: begin
				if (in_acc && (func == lgfs_pkg::FUNC_ADD) && a_ok && b_ok) begin
					cmd.en = 1'b1;
					mem_addr = in_addr;
				end
			end
			ST_ADD: begin
				cmd.en = 1'b1;
				cmd.we = 1'b1;
				cmd.wdata = rdata | (lgfs_pkg::ROW_W'(1) << b_q);
				mem_addr = add_addr_q;
			end
			ST_STEP: begin
				cmd.en = 1'b1;
				mem_addr = ADDR_W'(lab_q) * NC_A + ADDR_W'(cnt_q);
			end
			ST_STEP_END: begin
			end
			default: begin
			end
		endcase
	end

	lgfs_route_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.cmd   (cmd),
		.addr  (mem_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			known_q     <= '0;
			frontier_q  <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= stop_acc || (out_valid_q && out_stall);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (func)
							lgfs_pkg::FUNC_ADD: begin
								if (a_ok && b_ok) begin
									known_q <= known_q | (lgfs_pkg::ROW_W'(1) << city_a) |
										(lgfs_pkg::ROW_W'(1) << city_b);
									state_q <= ST_ADD;
								end
							end
							lgfs_pkg::FUNC_BEGIN: begin
								frontier_q <= (a_ok && known_q[city_a]) ?
									(lgfs_pkg::ROW_W'(1) << city_a) : '0;
							end
							lgfs_pkg::FUNC_STEP: begin
								cnt_q   <= '0;
								state_q <= ST_STEP;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD: begin
					state_q <= ST_IDLE;
				end
				ST_STEP: begin
					vld_s1 <= 1'b1;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_CITIES - 1)) begin
						state_q <= ST_STEP_END;
					end
				end
				ST_STEP_END: begin
					vld_s1     <= 1'b0;
					frontier_q <= acc_next & CITY_MASK;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_acc) begin
			lab_q      <= lab;
			add_addr_q <= in_addr;
			b_q        <= city_b;
			acc_q      <= '0;
			if (func == lgfs_pkg::FUNC_STOP) begin
				out_mask_q <= frontier_q;
				out_imp_q  <= (frontier_q == '0);
			end
		end else begin
			acc_q <= acc_next;
		end
		if (state_q == ST_STEP) begin
			sel_s1 <= frontier_q[cnt_q];
		end
	end

	assign out_valid      = out_valid_q;
	assign reachable_mask = out_mask_q;
	assign impossible     = out_imp_q;

endmodule

// File: design/lgfs_checker.sv
// Port-level checker for the labeled graph frontier stepper and its bind.
module lgfs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [lgfs_pkg::FUNC_W-1:0] func,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [lgfs_pkg::ROW_W-1:0]  reachable_mask,
	input logic                        impossible
);

	logic stop_acc;

	assign stop_acc = in_valid && !in_stall && (func == lgfs_pkg::FUNC_STOP);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reachable_mask) &&
			$stable(impossible))
		else $error("Stalled result changed or was dropped.");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (impossible == (reachable_mask == '0)))
		else $error("Impossible flag disagrees with the reachable mask.");

	a_rose_after_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stop_acc))
		else $error("Result appeared without an accepted stop transaction.");

	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !stop_acc |=> !out_valid)
		else $error("Result repeated after it was taken.");

endmodule

bind labeled_graph_frontier_step lgfs_checker u_lgfs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.func           (func),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.reachable_mask (reachable_mask),
	.impossible     (impossible)
);
